FILE: design/connection_table_with_refcounts_core_macros.svh
// ---------------------------------------------------------------------------
// Connection table assertion macros
// Shorthand for clocked implication checks with reset disable.
// ---------------------------------------------------------------------------
`ifndef CONNECTION_TABLE_WITH_REFCOUNTS_CORE_MACROS_SVH
`define CONNECTION_TABLE_WITH_REFCOUNTS_CORE_MACROS_SVH

// same-cycle implication
`define CTH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("connection table check failed");

// next-cycle implication
`define CTH_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("connection table check failed");

`endif

FILE: design/cth_pkg.sv
// ---------------------------------------------------------------------------
// Connection table package
// Shared types, codes and constants of the hashed connection table.
// ---------------------------------------------------------------------------
package cth_pkg;

  localparam int MAX_BINS   = 2048;
  localparam int BIN_W      = 11;
  localparam int FOLD_SHIFT = 12;
  localparam int KEY_W      = 128;

  localparam logic [15:0] AF_INET    = 16'd2;
  localparam logic [15:0] AF_IPX     = 16'd6;
  localparam logic [15:0] AF_COMPORT = 16'd69;

  typedef enum logic [1:0] {
    REQ_LOOKUP  = 2'd0,
    REQ_INSERT  = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BIN_FULL  = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // one way of a bin
  typedef struct packed {
    logic [15:0]      refs;
    logic [15:0]      handle;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

FILE: design/connection_table_with_refcounts_core.sv
// ---------------------------------------------------------------------------
// Hashed connection table with reference counts
// Lookup, insert and release of connections keyed by socket address.
// ---------------------------------------------------------------------------
// After reset the block clears its valid memory, one bin a cycle, across all
// 2048 bins, and holds busy high meanwhile. A request is taken when start is
// high and busy is low; its bin is read from memory in that same cycle, the
// bin is compared and written back in the next, and the result shows on the
// out_ ports with out_valid for one cycle after that. Busy is high while a
// request's bin is compared and written back, set by the single read-modify-write
// of the bin memory, so no new request is taken then. Results cannot be stalled.
module connection_table_with_refcounts_core import cth_pkg::*; #(
  parameter int WAYS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic [15:0]       in_family,
  input  logic [15:0]       in_addr_bytes_2_3,
  input  logic [63:0]       in_addr_bytes_4_11,
  input  logic [15:0]       in_addr_bytes_12_13,
  input  logic [15:0]       in_addr_bytes_14_15,
  input  logic [15:0]       in_conn_id,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [15:0]       out_found_id,
  output logic [15:0]       out_ref_count,
  output logic              out_removed,
  output logic [BIN_W-1:0]  out_bin_index,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  state_t           state_r, state_nxt;
  logic [BIN_W-1:0] clr_cnt_r;
  logic [3:0]       size_log_r;
  logic             accept;

  logic [1:0]       req_r;
  logic [KEY_W-1:0] key_r;
  logic [15:0]      fam_r;
  logic [15:0]      cid_r;
  logic [BIN_W-1:0] bin_r;
  logic [BIN_W-1:0] bin_in;

  logic [WAYS-1:0]   rd_valid;
  entry_t [WAYS-1:0] rd_data;
  logic [WAYS-1:0]   vrow_nxt;
  entry_t [WAYS-1:0] row_nxt;
  logic              wr_en;
  logic              wr_data_en;
  logic [BIN_W-1:0]  wr_addr;
  logic [WAYS-1:0]   wr_valid;

  logic [KEY_W-1:0] kmask;
  logic             found, has_free;
  logic [WAY_W-1:0] hit, freew;
  logic [15:0]      refs, new_refs;

  logic             out_valid_r;
  logic [1:0]       status_nxt, status_r;
  logic [15:0]      fid_nxt, fid_r;
  logic [15:0]      cnt_nxt, cnt_r;
  logic             gone_nxt, gone_r;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {28'd0, size_log_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log_r <= 4'd12;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      size_log_r <= pwdata[3:0];
    end
  end

  cth_hash u_hash (
    .family   (in_family),
    .b2_3     (in_addr_bytes_2_3),
    .b4_11    (in_addr_bytes_4_11),
    .b12_13   (in_addr_bytes_12_13),
    .size_log (size_log_r),
    .bin      (bin_in)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == BIN_W'(MAX_BINS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold the accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      fam_r <= in_family;
      cid_r <= in_conn_id;
      bin_r <= bin_in;
      key_r <= {in_addr_bytes_14_15, in_addr_bytes_12_13, in_addr_bytes_4_11,
                in_addr_bytes_2_3, in_family};
    end
  end

  cth_store #(.WAYS(WAYS)) u_store (
    .clk        (clk),
    .rd_en      (accept),
    .rd_addr    (bin_in),
    .rd_valid   (rd_valid),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_data_en (wr_data_en),
    .wr_addr    (wr_addr),
    .wr_valid   (wr_valid),
    .wr_data    (row_nxt)
  );

  // compared key bytes by family
  always_comb begin
    if (fam_r == AF_INET) begin
      kmask = {64'd0, {64{1'b1}}};
    end else if (fam_r == AF_IPX) begin
      kmask = {16'd0, {112{1'b1}}};
    end else if (fam_r == AF_COMPORT) begin
      kmask = {96'd0, {32{1'b1}}};
    end else begin
      kmask = '1;
    end
  end

  // pick the first matching way and the first free way
  always_comb begin
    found    = 1'b0;
    has_free = 1'b0;
    hit      = '0;
    freew    = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_valid[w]) begin
        if (((rd_data[w].key ^ key_r) & kmask) == '0) begin
          found = 1'b1;
          hit   = WAY_W'(w);
        end
      end else begin
        has_free = 1'b1;
        freew    = WAY_W'(w);
      end
    end
  end

  assign refs = rd_data[hit].refs;

  // modify the bin and form the result
  always_comb begin
    row_nxt    = rd_data;
    vrow_nxt   = rd_valid;
    status_nxt = ST_NOT_FOUND;
    fid_nxt    = 16'd0;
    cnt_nxt    = 16'd0;
    gone_nxt   = 1'b0;
    new_refs   = refs;
    case (req_r)
      REQ_LOOKUP: begin
        if (found) begin
          fid_nxt = rd_data[hit].handle;
          if (refs == 16'hFFFF) begin
            status_nxt = ST_SATURATED;
          end else begin
            new_refs   = refs + 16'd1;
            status_nxt = ST_OK;
          end
          row_nxt[hit].refs = new_refs;
          cnt_nxt = new_refs;
        end
      end
      REQ_INSERT: begin
        if (found || has_free) begin
          row_nxt[found ? hit : freew]  = '{refs: 16'd1, handle: cid_r, key: key_r};
          vrow_nxt[found ? hit : freew] = 1'b1;
          status_nxt = ST_OK;
          fid_nxt    = cid_r;
          cnt_nxt    = 16'd1;
        end else begin
          status_nxt = ST_BIN_FULL;
        end
      end
      REQ_RELEASE: begin
        if (found) begin
          fid_nxt  = rd_data[hit].handle;
          new_refs = (refs == 16'd0) ? 16'd0 : refs - 16'd1;
          row_nxt[hit].refs = new_refs;
          cnt_nxt  = new_refs;
          if (new_refs == 16'd0) begin
            vrow_nxt[hit] = 1'b0;
            gone_nxt      = 1'b1;
          end
          status_nxt = ST_OK;
        end
      end
      default: ;
    endcase
  end

  // write back the bin, or sweep the valid memory after reset
  assign wr_en      = (state_r == S_CLEAR) || (state_r == S_EXEC);
  assign wr_data_en = (state_r == S_EXEC);
  assign wr_addr    = (state_r == S_CLEAR) ? clr_cnt_r : bin_r;
  assign wr_valid   = (state_r == S_CLEAR) ? '0 : vrow_nxt;

  // drive the result for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      status_r <= status_nxt;
      fid_r    <= fid_nxt;
      cnt_r    <= cnt_nxt;
      gone_r   <= gone_nxt;
    end
  end

  logic [BIN_W-1:0] obin_r;
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) obin_r <= bin_r;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_found_id  = fid_r;
  assign out_ref_count = cnt_r;
  assign out_removed   = gone_r;
  assign out_bin_index = obin_r;

endmodule

FILE: design/cth_hash.sv
// ---------------------------------------------------------------------------
// Connection table bin hash
// Maps family and address bytes to a bin under the configured table size.
// ---------------------------------------------------------------------------
module cth_hash import cth_pkg::*; (
  input  logic [15:0]      family,
  input  logic [15:0]      b2_3,
  input  logic [63:0]      b4_11,
  input  logic [15:0]      b12_13,
  input  logic [3:0]       size_log,
  output logic [BIN_W-1:0] bin
);

  logic [7:0]       bytes [10];
  logic [15:0]      pair [5];
  logic [15:0]      ipx_sum;
  logic [15:0]      inet_h;
  logic [15:0]      hv;
  logic [3:0]       lg;
  logic [BIN_W-1:0] mask;

  // split address bytes for the ipx sum
  always_comb begin
    bytes[0] = b2_3[7:0];
    bytes[1] = b2_3[15:8];
    for (int i = 0; i < 8; i++) begin
      bytes[2+i] = b4_11[8*i +: 8];
    end
  end

  // sum signed bytes pairwise, then fold in the socket
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      pair[i] = {{8{bytes[2*i][7]}}, bytes[2*i]} + {{8{bytes[2*i+1][7]}}, bytes[2*i+1]};
    end
    ipx_sum = b12_13;
    for (int i = 0; i < 5; i++) begin
      ipx_sum = ipx_sum + pair[i];
    end
  end

  // fold the inet address at 12 and 24 bits
  assign inet_h = b2_3 ^ b4_11[15:0] ^ b4_11[FOLD_SHIFT +: 16] ^ {8'd0, b4_11[31:24]};

  always_comb begin
    if (family == AF_INET) begin
      hv = inet_h;
    end else if (family == AF_IPX) begin
      hv = ipx_sum;
    end else begin
      hv = 16'd0;
    end
  end

  // clamp size and mask to the bin count
  always_comb begin
    lg = size_log;
    if (lg < 4'd1) lg = 4'd1;
    if (lg > 4'(FOLD_SHIFT)) lg = 4'(FOLD_SHIFT);
    mask = BIN_W'((12'd1 << (lg - 4'd1)) - 12'd1);
  end

  assign bin = hv[BIN_W-1:0] & mask;

endmodule

FILE: design/cth_store.sv
// ---------------------------------------------------------------------------
// Connection table storage
// Bin-wide valid memory and entry memory, one read and one write port each.
// ---------------------------------------------------------------------------
module cth_store import cth_pkg::*; #(
  parameter int WAYS = 4
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [BIN_W-1:0]      rd_addr,
  output logic [WAYS-1:0]       rd_valid,
  output entry_t [WAYS-1:0]     rd_data,
  input  logic                  wr_en,
  input  logic                  wr_data_en,
  input  logic [BIN_W-1:0]      wr_addr,
  input  logic [WAYS-1:0]       wr_valid,
  input  entry_t [WAYS-1:0]     wr_data
);

  logic [WAYS-1:0]   vld_mem [MAX_BINS];
  entry_t [WAYS-1:0] dat_mem [MAX_BINS];

  // write valid row, and entries when asked
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vld_mem[wr_addr] <= wr_valid;
      if (wr_data_en) begin
        dat_mem[wr_addr] <= wr_data;
      end
    end
  end

  // registered read of one bin
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid <= vld_mem[rd_addr];
      rd_data  <= dat_mem[rd_addr];
    end
  end

endmodule

FILE: design/cth_checker.sv
// ---------------------------------------------------------------------------
// Connection table port checker
// Timing and result consistency checks on the top-level ports.
// ---------------------------------------------------------------------------
`include "connection_table_with_refcounts_core_macros.svh"

module cth_checker import cth_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [1:0]        out_status,
  input logic [15:0]       out_found_id,
  input logic [15:0]       out_ref_count,
  input logic              out_removed
);

  // an accepted transfer keeps the block busy for its execute cycle
  `CTH_ASSERT_NXT(a_accept_busy, start && !busy, busy)

  // every accepted transfer gives a result, registered out of its execute state
  `CTH_ASSERT_NXT(a_accept_result, start && !busy, ##1 out_valid)

  // a result shows only once the block is free again
  `CTH_ASSERT_IMP(a_result_idle, out_valid, !busy)

  // a miss reports empty fields
  `CTH_ASSERT_IMP(a_miss_clean, out_valid && out_status == ST_NOT_FOUND,
                  out_found_id == 16'd0 && out_ref_count == 16'd0 && !out_removed)

  // a removal is a successful release down to zero
  `CTH_ASSERT_IMP(a_removed_zero, out_valid && out_removed,
                  out_status == ST_OK && out_ref_count == 16'd0)

endmodule

bind connection_table_with_refcounts_core cth_checker u_cth_checker (.*);

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// Connection table testbench
// Drives lookup, insert and release requests through the command port,
// predicts each result from a local model of the hashed table or a directed row, and checks
// every result strobe against the oldest prediction. Covers directed corner
// rows, a short run of added references, and random phases over several
// table sizes.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import cth_pkg::*;

  localparam int WAYS  = 4;
  localparam int SLOTS = MAX_BINS * WAYS;
  localparam int POOL  = 24;

  typedef struct {
    logic [1:0]  req;
    logic [15:0] fam;
    logic [15:0] b23;
    logic [63:0] b411;
    logic [15:0] b12;
    logic [15:0] b14;
    logic [15:0] cid;
  } conn_req_t;

  typedef struct {
    logic [1:0]       status;
    logic [15:0]      fid;
    logic [15:0]      cnt;
    logic             rem;
    logic [BIN_W-1:0] bin;
  } conn_rsp_t;

  typedef struct {
    conn_req_t req;
    logic      typed;
    conn_rsp_t rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0]  in_req_type;
  logic [15:0] in_family, in_addr_bytes_2_3, in_addr_bytes_12_13;
  logic [15:0] in_addr_bytes_14_15, in_conn_id;
  logic [63:0] in_addr_bytes_4_11;
  logic out_valid, out_removed;
  logic [1:0] out_status;
  logic [15:0] out_found_id, out_ref_count;
  logic [BIN_W-1:0] out_bin_index;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  // model of the table
  logic [3:0]  tbl_size_log;
  logic        tbl_valid [SLOTS];
  logic [63:0] tbl_key_lo [SLOTS];
  logic [63:0] tbl_key_hi [SLOTS];
  logic [15:0] tbl_handle [SLOTS];
  logic [15:0] tbl_refs [SLOTS];

  conn_rsp_t pending_rsp [$];
  int mismatches = 0;
  int idle_pct = 0;
  conn_req_t key_pool [POOL];

  connection_table_with_refcounts_core #(.WAYS(WAYS)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_family(in_family),
    .in_addr_bytes_2_3(in_addr_bytes_2_3), .in_addr_bytes_4_11(in_addr_bytes_4_11),
    .in_addr_bytes_12_13(in_addr_bytes_12_13), .in_addr_bytes_14_15(in_addr_bytes_14_15),
    .in_conn_id(in_conn_id), .out_valid(out_valid), .out_status(out_status),
    .out_found_id(out_found_id), .out_ref_count(out_ref_count),
    .out_removed(out_removed), .out_bin_index(out_bin_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // hash an address to its bin
  function automatic logic [BIN_W-1:0] hash_bin(conn_req_t r);
    int lg;
    logic [15:0] hv;
    logic [31:0] a;
    logic [7:0] by [10];
    lg = tbl_size_log;
    if (lg < 1) lg = 1;
    if (lg > FOLD_SHIFT) lg = FOLD_SHIFT;
    a = r.b411[31:0];
    if (r.fam == AF_INET) begin
      hv = r.b23 ^ a[15:0] ^ a[27:12] ^ {8'h00, a[31:24]};
    end else if (r.fam == AF_IPX) begin
      by[0] = r.b23[7:0];
      by[1] = r.b23[15:8];
      for (int i = 0; i < 8; i++) by[2+i] = r.b411[8*i +: 8];
      hv = r.b12;
      for (int i = 0; i < 10; i++) hv = hv + {{8{by[i][7]}}, by[i]};
    end else begin
      hv = 16'h0;
    end
    hv = hv & ((16'd1 << (lg - 1)) - 16'd1);
    return hv[BIN_W-1:0];
  endfunction

  // apply one request to the table model and return its result
  function automatic conn_rsp_t table_update(conn_req_t r);
    conn_rsp_t o;
    logic [63:0] lo, hi, mlo, mhi;
    int base, hit, freew;
    bit found, has_free;
    lo = {r.b411[31:0], r.b23, r.fam};
    hi = {r.b14, r.b12, r.b411[63:32]};
    mlo = '1;
    mhi = '1;
    if (r.fam == AF_INET) mhi = '0;
    else if (r.fam == AF_IPX) mhi = 64'h0000_FFFF_FFFF_FFFF;
    else if (r.fam == AF_COMPORT) begin
      mlo = 64'hFFFF_FFFF;
      mhi = '0;
    end
    o.bin = hash_bin(r);
    o.status = ST_NOT_FOUND;
    o.fid = '0;
    o.cnt = '0;
    o.rem = 1'b0;
    base = int'(o.bin) * WAYS;
    found = 0;
    has_free = 0;
    hit = 0;
    freew = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (tbl_valid[base+w]) begin
        if (!found && ((tbl_key_lo[base+w] ^ lo) & mlo) == 0 &&
            ((tbl_key_hi[base+w] ^ hi) & mhi) == 0) begin
          found = 1;
          hit = base + w;
        end
      end else if (!has_free) begin
        has_free = 1;
        freew = base + w;
      end
    end
    case (r.req)
      REQ_LOOKUP: if (found) begin
        o.fid = tbl_handle[hit];
        if (tbl_refs[hit] == 16'hFFFF) o.status = ST_SATURATED;
        else begin
          tbl_refs[hit]++;
          o.status = ST_OK;
        end
        o.cnt = tbl_refs[hit];
      end
      REQ_INSERT: if (found || has_free) begin
        if (!found) hit = freew;
        tbl_valid[hit] = 1'b1;
        tbl_key_lo[hit] = lo;
        tbl_key_hi[hit] = hi;
        tbl_handle[hit] = r.cid;
        tbl_refs[hit] = 16'd1;
        o.status = ST_OK;
        o.fid = r.cid;
        o.cnt = 16'd1;
      end else begin
        o.status = ST_BIN_FULL;
      end
      REQ_RELEASE: if (found) begin
        o.fid = tbl_handle[hit];
        if (tbl_refs[hit] != 0) tbl_refs[hit]--;
        o.cnt = tbl_refs[hit];
        if (o.cnt == 0) begin
          tbl_valid[hit] = 1'b0;
          o.rem = 1'b1;
        end
        o.status = ST_OK;
      end
      default: ;
    endcase
    return o;
  endfunction

  // transfer one request; hold start until accepted
  task automatic send_req(conn_req_t r, bit typed, conn_rsp_t typed_rsp);
    conn_rsp_t p;
    start <= 1'b1;
    in_req_type <= r.req;
    in_family <= r.fam;
    in_addr_bytes_2_3 <= r.b23;
    in_addr_bytes_4_11 <= r.b411;
    in_addr_bytes_12_13 <= r.b12;
    in_addr_bytes_14_15 <= r.b14;
    in_conn_id <= r.cid;
    do @(posedge clk); while (busy);
    p = table_update(r);
    pending_rsp.push_back(typed ? typed_rsp : p);
    // random gap before the next request
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // drain results, then write the size register
  task automatic write_size(logic [3:0] v);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= '0;
    pwdata <= {28'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tbl_size_log = v;
  endtask

  function automatic conn_req_t rand_req();
    conn_req_t r;
    r.req = 2'($urandom_range(3));
    r.fam = 16'($urandom);
    case ($urandom_range(3))
      0: r.fam = AF_INET;
      1: r.fam = AF_IPX;
      2: r.fam = AF_COMPORT;
      default: ;
    endcase
    r.b23 = 16'($urandom);
    r.b411 = {$urandom, $urandom};
    r.b12 = 16'($urandom);
    r.b14 = 16'($urandom);
    r.cid = 16'($urandom);
    return r;
  endfunction

  // check every result strobe against the oldest prediction
  always @(posedge clk) begin
    conn_rsp_t e;
    if (rst_n && out_valid) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = pending_rsp.pop_front();
        if (out_status !== e.status || out_found_id !== e.fid ||
            out_ref_count !== e.cnt || out_removed !== e.rem ||
            out_bin_index !== e.bin) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: exp st=%0d id=%h cnt=%0d rm=%0d bin=%0d",
                      " got st=%0d id=%h cnt=%0d rm=%0d bin=%0d"},
                     $realtime, e.status, e.fid, e.cnt, e.rem, e.bin, out_status,
                     out_found_id, out_ref_count, out_removed, out_bin_index);
        end
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t rows [$];
    dir_row_t d;
    conn_req_t r, sat_key;
    conn_rsp_t none;
    logic [3:0] sizes [6];
    int idles [3];
    int pick;

    sizes = '{4'd1, 4'd3, 4'd12, 4'd0, 4'd15, 4'd6};
    idles = '{31, 54, 0};
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req_type <= REQ_LOOKUP;
    in_family <= '0;
    in_addr_bytes_2_3 <= '0;
    in_addr_bytes_4_11 <= '0;
    in_addr_bytes_12_13 <= '0;
    in_addr_bytes_14_15 <= '0;
    in_conn_id <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tbl_size_log = 4'd12;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key_lo[i] = '0;
      tbl_key_hi[i] = '0;
      tbl_handle[i] = '0;
      tbl_refs[i] = '0;
    end
    none = '{ST_NOT_FOUND, 16'h0, 16'h0, 1'b0, '0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows; families 0, 69 and ffff all hash to bin 0
    rows.push_back('{'{REQ_LOOKUP, 16'h0, 16'h0, 64'h0, 16'h0, 16'h0, 16'h0}, 1'b1, none});
    rows.push_back('{'{REQ_RELEASE, '1, '1, '1, '1, '1, '1}, 1'b1, none});
    rows.push_back('{'{REQ_NONE, AF_INET, 16'h1234, 64'hDEAD_BEEF, 16'h0, 16'h0, 16'h7},
                    1'b0, none});
    rows.push_back('{'{REQ_INSERT, 16'h0, 16'h0, 64'h0, 16'h0, 16'h0, '1}, 1'b1,
                    '{ST_OK, 16'hFFFF, 16'd1, 1'b0, '0}});
    rows.push_back('{'{REQ_LOOKUP, 16'h0, 16'h0, 64'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
                    '{ST_OK, 16'hFFFF, 16'd2, 1'b0, '0}});
    rows.push_back('{'{REQ_RELEASE, 16'h0, 16'h0, 64'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
                    '{ST_OK, 16'hFFFF, 16'd1, 1'b0, '0}});
    rows.push_back('{'{REQ_RELEASE, 16'h0, 16'h0, 64'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
                    '{ST_OK, 16'hFFFF, 16'd0, 1'b1, '0}});
    rows.push_back('{'{REQ_LOOKUP, 16'h0, 16'h0, 64'h0, 16'h0, 16'h0, 16'h0}, 1'b1, none});
    rows.push_back('{'{REQ_INSERT, AF_INET, '1, '1, '1, '1, 16'h0101}, 1'b0, none});
    rows.push_back('{'{REQ_LOOKUP, AF_INET, '1, '1, 16'h0, 16'h0, 16'h0}, 1'b0, none});
    rows.push_back('{'{REQ_INSERT, AF_IPX, 16'h80FF, 64'h8081_7F00_FF80_0180, 16'hFFFF,
                      16'h0, 16'h0202}, 1'b0, none});
    rows.push_back('{'{REQ_LOOKUP, AF_IPX, 16'h80FF, 64'h8081_7F00_FF80_0180, 16'hFFFF,
                      16'h5A5A, 16'h0}, 1'b0, none});
    rows.push_back('{'{REQ_INSERT, AF_COMPORT, 16'hABCD, 64'h1, 16'h2, 16'h3, 16'h0303},
                    1'b0, none});
    rows.push_back('{'{REQ_LOOKUP, AF_COMPORT, 16'hABCD, '1, '1, '1, 16'h0}, 1'b0, none});
    rows.push_back('{'{REQ_INSERT, AF_COMPORT, 16'hABCD, 64'h0, 16'h0, 16'h0, 16'h0404},
                    1'b0, none});
    for (int i = 1; i <= 4; i++)
      rows.push_back('{'{REQ_INSERT, '1, 16'h0, 64'h0, 16'h0, 16'(i), 16'(i)}, 1'b0, none});
    rows.push_back('{'{REQ_LOOKUP, '1, 16'h0, 64'h0, 16'h0, 16'd3, 16'h0}, 1'b0, none});
    rows.push_back('{'{REQ_RELEASE, '1, 16'h0, 64'h0, 16'h0, 16'd2, 16'h0}, 1'b0, none});
    rows.push_back('{'{REQ_INSERT, '1, 16'h0, 64'h0, 16'h0, 16'd9, 16'h0909}, 1'b0, none});
    foreach (rows[i]) begin
      d = rows[i];
      send_req(d.req, d.typed, d.rsp);
    end

    // add a run of references to one entry
    sat_key = '{REQ_INSERT, AF_INET, 16'h4321, 64'h0A0B_0C0D, 16'h0, 16'h0, 16'hBEEF};
    send_req(sat_key, 1'b0, none);
    sat_key.req = REQ_LOOKUP;
    for (int i = 0; i < 8; i++) send_req(sat_key, 1'b0, none);

    // random phases over table sizes and gap rates
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      idle_pct = idles[p % 3];
      for (int k = 0; k < POOL; k++) key_pool[k] = rand_req();
      for (int n = 0; n < 240; n++) begin
        if ($urandom_range(99) < 80) begin
          pick = $urandom_range(POOL - 1);
          r = key_pool[pick];
          r.cid = 16'($urandom);
          pick = $urandom_range(99);
          r.req = (pick < 30) ? REQ_INSERT : (pick < 70) ? REQ_LOOKUP :
                  (pick < 95) ? REQ_RELEASE : REQ_NONE;
        end else begin
          r = rand_req();
        end
        send_req(r, 1'b0, none);
      end
    end

    // drain and report
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  // run time limit
  initial begin
    #20_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
